>>> sv/hrs_pkg.sv
`timescale 1ns / 1ps

package hrs_pkg;

	// Register file depth default
	localparam int REG_COUNT_DEF = 32;

	// Function codes
	localparam logic [7:0] FUNC_READ   = 8'd3;
	localparam logic [7:0] FUNC_WRITE1 = 8'd6;
	localparam logic [7:0] FUNC_WRITEN = 8'd16;

	// Exception codes
	localparam logic [15:0] EXC_ILLEGAL_FUNC = 16'd1;
	localparam logic [15:0] EXC_ADDR         = 16'd2;

	// Response status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_ADDR_ERR = 2'd1;
	localparam logic [1:0] STAT_ILLEGAL  = 2'd2;

	// Saturation point of the multi-write word counter
	localparam logic [5:0] OFFSET_MAX = 6'd63;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RANGE,
		S_EXEC,
		S_W16,
		S_RD_ADDR,
		S_RD_DATA,
		S_RESP
	} hrs_state_t;

	// Exception function code: code plus 0x80, modulo 256
	function automatic logic [7:0] exc_func(input logic [7:0] f);
		exc_func = {~f[7], f[6:0]};
	endfunction

endpackage

>>> sv/hrs_ram.sv
`timescale 1ns / 1ps

module hrs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/hrs_addr_unit.sv
`timescale 1ns / 1ps

module hrs_addr_unit #(
	parameter int REG_COUNT = 32
) (
	input  logic [15:0] opa,
	input  logic [15:0] opb,
	output logic [16:0] sum,
	output logic        fits,
	output logic        below
);

	localparam logic [16:0] LIMIT = 17'(REG_COUNT);

	// Shared 17-bit adder with the bound compares
	assign sum   = {1'b0, opa} + {1'b0, opb};
	assign fits  = (sum <= LIMIT);
	assign below = (sum < LIMIT);

endmodule

>>> sv/modbus_holding_register_server_unit.sv
`timescale 1ns / 1ps
// Channel | Handshake            | Payload
// ------- | -------------------- | ------------------------------------------------
// input   | in_valid / in_stall  | func, start_address, quantity, write_word, word_last
// output  | out_valid / out_stall| resp_func, word_a, word_b, status, last
//
// One transaction is worked at a time; in_stall is high until the sequencer is idle.
// Code 6 and exceptions go S_RANGE, S_EXEC, S_RESP; code 16 words go S_RANGE, S_EXEC,
// S_W16, plus S_RESP for the echo. Code 3: header via S_RESP, then per register word
// S_RD_ADDR (shared address adder), S_RD_DATA (registered RAM read) and S_RESP.
// Reset clears the sequencer, the word counter and the per-entry valid bits at once;
// an entry never written reads as zero. A stalled result holds in the output register
// and the sequencer waits on it before pushing the next one.

module modbus_holding_register_server_unit #(
	parameter int REG_COUNT = hrs_pkg::REG_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  func,
	input  logic [15:0] start_address,
	input  logic [15:0] quantity,
	input  logic [15:0] write_word,
	input  logic        word_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  resp_func,
	output logic [15:0] word_a,
	output logic [15:0] word_b,
	output logic [1:0]  status,
	output logic        last
);

	import hrs_pkg::*;

	localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int CW = $clog2(REG_COUNT + 1);

	hrs_state_t state_q, state_nx;

	// Captured request
	logic [7:0]  func_q;
	logic [15:0] addr_q;
	logic [15:0] qty_q;
	logic [15:0] word_q;
	logic        wlast_q;

	// Sequencer bookkeeping
	logic          in_range_q;
	logic [5:0]    woff_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_nx;
	logic          more_q;
	logic          hit_q;
	logic [REG_COUNT-1:0] vld_q;

	// Pending response, pushed to the output register in S_RESP
	logic [7:0]  rsp_func_q;
	logic [15:0] rsp_a_q;
	logic [15:0] rsp_b_q;
	logic [1:0]  rsp_stat_q;
	logic        rsp_last_q;

	// Output register
	logic        out_valid_q;
	logic [7:0]  out_func_q;
	logic [15:0] out_a_q;
	logic [15:0] out_b_q;
	logic [1:0]  out_stat_q;
	logic        out_last_q;

	// Shared address unit
	logic [15:0] opb;
	logic [16:0] sum;
	logic        fits;
	logic        below;

	// RAM port
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          rd_en;
	logic [15:0]   rd_data;

	logic in_acc;
	logic slot_free;
	logic w16_ok;
	logic cnt_done;

	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cnt_nx    = cnt_q + 1'b1;
	assign cnt_done  = (16'(cnt_nx) == qty_q);
	assign w16_ok    = in_range_q && (16'(woff_q) < qty_q) && below;

	// Operand select for the shared adder
	always_comb begin
		case (state_q)
			S_RANGE:   opb = (func_q == FUNC_WRITE1) ? 16'd0 : qty_q;
			S_W16:     opb = 16'(woff_q);
			S_RD_ADDR: opb = 16'(cnt_q);
			default:   opb = 16'd0;
		endcase
	end

	hrs_addr_unit #(
		.REG_COUNT(REG_COUNT)
	) u_addr (
		.opa  (addr_q),
		.opb  (opb),
		.sum  (sum),
		.fits (fits),
		.below(below)
	);

	hrs_ram #(
		.WIDTH(16),
		.DEPTH(REG_COUNT),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(word_q),
		.rd_en  (rd_en),
		.rd_addr(sum[AW-1:0]),
		.rd_data(rd_data)
	);

	// Next state and RAM strobes
	always_comb begin
		state_nx = state_q;
		wr_en    = 1'b0;
		wr_addr  = sum[AW-1:0];
		rd_en    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_nx = S_RANGE;
				end
			end
			S_RANGE: begin
				state_nx = S_EXEC;
			end
			S_EXEC: begin
				case (func_q)
					FUNC_WRITE1: begin
						wr_en    = in_range_q;
						wr_addr  = addr_q[AW-1:0];
						state_nx = S_RESP;
					end
					FUNC_WRITEN: state_nx = S_W16;
					default:     state_nx = S_RESP;
				endcase
			end
			S_W16: begin
				wr_en    = w16_ok;
				state_nx = wlast_q ? S_RESP : S_IDLE;
			end
			S_RD_ADDR: begin
				rd_en    = 1'b1;
				state_nx = S_RD_DATA;
			end
			S_RD_DATA: begin
				state_nx = S_RESP;
			end
			S_RESP: begin
				if (slot_free) begin
					state_nx = more_q ? S_RD_ADDR : S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			woff_q      <= '0;
			cnt_q       <= '0;
			more_q      <= 1'b0;
			vld_q       <= '0;
		end else begin
			state_q <= state_nx;

			// Drop the output once taken, load it when the slot frees up
			if (state_q == S_RESP && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			// Any item but a multi-write restarts the word counter
			if (in_acc && func != FUNC_WRITEN) begin
				woff_q <= '0;
			end
			if (state_q == S_W16) begin
				if (wlast_q) begin
					woff_q <= '0;
				end else if (woff_q < OFFSET_MAX) begin
					woff_q <= woff_q + 1'b1;
				end
			end

			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end

			case (state_q)
				S_EXEC: begin
					cnt_q  <= '0;
					more_q <= (func_q == FUNC_READ) && in_range_q && (qty_q != 16'd0);
				end
				S_W16: begin
					more_q <= 1'b0;
				end
				S_RD_DATA: begin
					cnt_q  <= cnt_nx;
					more_q <= !cnt_done;
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q  <= func;
			addr_q  <= start_address;
			qty_q   <= quantity;
			word_q  <= write_word;
			wlast_q <= word_last;
		end

		if (state_q == S_RANGE) begin
			in_range_q <= (func_q == FUNC_WRITE1) ? below : fits;
		end

		// Hold the valid bit of the entry being read next to its data
		if (state_q == S_RD_ADDR) begin
			hit_q <= below && vld_q[sum[AW-1:0]];
		end

		case (state_q)
			S_EXEC: begin
				rsp_last_q <= 1'b1;
				rsp_b_q    <= 16'd0;
				case (func_q)
					FUNC_WRITE1: begin
						if (in_range_q) begin
							rsp_func_q <= func_q;
							rsp_a_q    <= addr_q;
							rsp_b_q    <= word_q;
							rsp_stat_q <= STAT_OK;
						end else begin
							rsp_func_q <= exc_func(func_q);
							rsp_a_q    <= EXC_ADDR;
							rsp_stat_q <= STAT_ADDR_ERR;
						end
					end
					FUNC_READ: begin
						if (in_range_q) begin
							// Header: byte count is twice the quantity
							rsp_func_q <= func_q;
							rsp_a_q    <= {qty_q[14:0], 1'b0};
							rsp_stat_q <= STAT_OK;
							rsp_last_q <= (qty_q == 16'd0);
						end else begin
							rsp_func_q <= exc_func(func_q);
							rsp_a_q    <= EXC_ADDR;
							rsp_stat_q <= STAT_ADDR_ERR;
						end
					end
					FUNC_WRITEN: ;
					default: begin
						rsp_func_q <= exc_func(func_q);
						rsp_a_q    <= EXC_ILLEGAL_FUNC;
						rsp_stat_q <= STAT_ILLEGAL;
					end
				endcase
			end
			S_W16: begin
				rsp_last_q <= 1'b1;
				if (in_range_q) begin
					rsp_func_q <= func_q;
					rsp_a_q    <= addr_q;
					rsp_b_q    <= qty_q;
					rsp_stat_q <= STAT_OK;
				end else begin
					rsp_func_q <= exc_func(func_q);
					rsp_a_q    <= EXC_ADDR;
					rsp_b_q    <= 16'd0;
					rsp_stat_q <= STAT_ADDR_ERR;
				end
			end
			S_RD_DATA: begin
				rsp_func_q <= func_q;
				rsp_a_q    <= hit_q ? rd_data : 16'd0;
				rsp_b_q    <= 16'd0;
				rsp_stat_q <= STAT_OK;
				rsp_last_q <= cnt_done;
			end
			default: ;
		endcase

		if (state_q == S_RESP && slot_free) begin
			out_func_q <= rsp_func_q;
			out_a_q    <= rsp_a_q;
			out_b_q    <= rsp_b_q;
			out_stat_q <= rsp_stat_q;
			out_last_q <= rsp_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign resp_func = out_func_q;
	assign word_a    = out_a_q;
	assign word_b    = out_b_q;
	assign status    = out_stat_q;
	assign last      = out_last_q;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import hrs_pkg::*;

	localparam int REG_COUNT = REG_COUNT_DEF;
	// Exception replies carry the function code with the top bit flipped (code + 0x80)
	localparam logic [7:0] EXC_FLAG = 8'h80;
	localparam int RANDOM_ITEMS = 256;
	localparam int IDLE_PCT = 14;
	// Long receiver hold-off that backs the server up into its input
	localparam int BACKLOG_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 40;

	typedef enum logic {
		REQ_SEND,
		REQ_DRAIN
	} req_kind_t;

	// One request transaction, or a marker that pauses the sender until all replies are in
	typedef struct {
		req_kind_t   kind;
		logic [7:0]  func;
		logic [15:0] addr;
		logic [15:0] qty;
		logic [15:0] word;
		logic        wlast;
	} request_t;

	// One reply transaction as the server should emit it
	typedef struct {
		logic [7:0]  func;
		logic [15:0] a;
		logic [15:0] b;
		logic [1:0]  st;
		logic        lst;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  func = '0;
	logic [15:0] start_address = '0;
	logic [15:0] quantity = '0;
	logic [15:0] write_word = '0;
	logic        word_last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  resp_func;
	logic [15:0] word_a;
	logic [15:0] word_b;
	logic [1:0]  status;
	logic        last;

	// Shadow copy of the holding registers and the multi-write word counter
	logic [15:0] hr_file [0:REG_COUNT-1];
	logic [5:0]  w16_offset = '0;

	request_t request_q[$];
	reply_t   awaited_replies[$];

	int stim_items = 0;
	int issued = 0;
	int requests_taken = 0;
	int replies_seen = 0;
	int errors = 0;
	int idle_cycles = 0;
	int hold_left = 0;
	bit backlog_done = 1'b0;

	modbus_holding_register_server_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.start_address(start_address),
		.quantity(quantity),
		.write_word(write_word),
		.word_last(word_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.resp_func(resp_func),
		.word_a(word_a),
		.word_b(word_b),
		.status(status),
		.last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void push_reply(input logic [7:0] f, input logic [15:0] a,
			input logic [15:0] b, input logic [1:0] st, input logic lst);
		reply_t r;
		r.func = f;
		r.a = a;
		r.b = b;
		r.st = st;
		r.lst = lst;
		awaited_replies.push_back(r);
	endfunction

	// Apply one accepted request to the shadow register file and queue its replies.
	// The range check runs on the 17-bit sum, so a wrapping address never passes.
	function automatic void serve_request(input logic [7:0] f, input logic [15:0] a,
			input logic [15:0] q, input logic [15:0] w, input logic wl);
		logic [16:0] span;
		logic fits;
		int idx;
		span = {1'b0, a} + {1'b0, q};
		fits = span <= 17'(REG_COUNT);
		// Anything but a multi-write breaks a running multi-write
		if (f != FUNC_WRITEN)
			w16_offset = '0;
		case (f)
		FUNC_WRITE1: begin
			if (int'(a) < REG_COUNT) begin
				hr_file[a] = w;
				push_reply(FUNC_WRITE1, a, w, STAT_OK, 1'b1);
			end else begin
				push_reply(f + EXC_FLAG, EXC_ADDR, '0, STAT_ADDR_ERR, 1'b1);
			end
		end
		FUNC_READ: begin
			if (!fits) begin
				push_reply(f + EXC_FLAG, EXC_ADDR, '0, STAT_ADDR_ERR, 1'b1);
			end else begin
				// Header holds the byte count; it closes the reply on its own when empty
				push_reply(FUNC_READ, {q[14:0], 1'b0}, '0, STAT_OK, q == '0);
				for (int i = 0; i < int'(q); i++) begin
					idx = int'(a) + i;
					push_reply(FUNC_READ, hr_file[idx], '0, STAT_OK, (i + 1) == int'(q));
				end
			end
		end
		FUNC_WRITEN: begin
			// Drop surplus words and every word of a request out of range
			if (fits && w16_offset < q) begin
				idx = int'(a) + int'(w16_offset);
				if (idx < REG_COUNT)
					hr_file[idx] = w;
			end
			if (w16_offset != OFFSET_MAX)
				w16_offset = w16_offset + 6'd1;
			if (wl) begin
				w16_offset = '0;
				if (fits)
					push_reply(FUNC_WRITEN, a, q, STAT_OK, 1'b1);
				else
					push_reply(f + EXC_FLAG, EXC_ADDR, '0, STAT_ADDR_ERR, 1'b1);
			end
		end
		default: push_reply(f + EXC_FLAG, EXC_ILLEGAL_FUNC, '0, STAT_ILLEGAL, 1'b1);
		endcase
	endfunction

	task automatic add_req(input logic [7:0] f, input logic [15:0] a, input logic [15:0] q,
			input logic [15:0] w, input logic wl);
		request_t r;
		r.kind = REQ_SEND;
		r.func = f;
		r.addr = a;
		r.qty = q;
		r.word = w;
		r.wlast = wl;
		request_q.push_back(r);
		stim_items++;
	endtask

	task automatic add_drain();
		request_t r;
		r.kind = REQ_DRAIN;
		r.func = '0;
		r.addr = '0;
		r.qty = '0;
		r.word = '0;
		r.wlast = 1'b0;
		request_q.push_back(r);
	endtask

	// Queue a multi-write of n data words; mark the final word last only when asked
	task automatic add_write_multi(input logic [15:0] a, input logic [15:0] q, input int n,
			input logic end_last);
		for (int k = 0; k < n; k++)
			add_req(FUNC_WRITEN, a, q, 16'($urandom), end_last && (k == n - 1));
	endtask

	// Register count for an in-range request: mostly short, now and then the whole room
	function automatic int pick_count(input int room);
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, room);
		return $urandom_range(0, room < 4 ? room : 4);
	endfunction

	// Driver: present requests at the falling edge, hold a transaction until it is taken
	always @(negedge clk) begin
		request_t nxt;
		if (arst_n && !(in_valid && requests_taken != issued)) begin
			// Release the pause marker once every reply has come back
			if (request_q.size() != 0 && request_q[0].kind == REQ_DRAIN &&
					awaited_replies.size() == 0)
				request_q.delete(0);
			if (request_q.size() == 0 || request_q[0].kind == REQ_DRAIN ||
					(!(issued >= 170 && issued < 230) && $urandom_range(0, 99) < IDLE_PCT)) begin
				in_valid <= 1'b0;
			end else begin
				nxt = request_q.pop_front();
				func <= nxt.func;
				start_address <= nxt.addr;
				quantity <= nxt.qty;
				write_word <= nxt.word;
				word_last <= nxt.wlast;
				in_valid <= 1'b1;
				issued++;
			end
		end
	end

	// Receiver: stall at random, hold off once for a long stretch, and keep a quiet window
	always @(negedge clk) begin
		if (arst_n) begin
			if (!backlog_done && replies_seen >= 100) begin
				hold_left = BACKLOG_CYCLES;
				backlog_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (replies_seen >= 140 && replies_seen < 200) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= $urandom_range(0, 99) < IDLE_PCT;
			end
		end
	end

	// Monitor: check replies against the oldest expectation first, then predict from
	// the request taken at this edge; its replies cannot appear at the same edge
	always @(posedge clk) begin
		reply_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			replies_seen++;
			if (awaited_replies.size() == 0) begin
				$error("unexpected reply: resp_func=%h word_a=%h word_b=%h status=%0d last=%b",
					resp_func, word_a, word_b, status, last);
				errors++;
			end else begin
				exp_r = awaited_replies.pop_front();
				if (resp_func !== exp_r.func) begin
					$error("resp_func: expected %h, got %h", exp_r.func, resp_func);
					errors++;
				end
				if (word_a !== exp_r.a) begin
					$error("word_a: expected %h, got %h", exp_r.a, word_a);
					errors++;
				end
				if (word_b !== exp_r.b) begin
					$error("word_b: expected %h, got %h", exp_r.b, word_b);
					errors++;
				end
				if (status !== exp_r.st) begin
					$error("status: expected %0d, got %0d", exp_r.st, status);
					errors++;
				end
				if (last !== exp_r.lst) begin
					$error("last: expected %b, got %b", exp_r.lst, last);
					errors++;
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			requests_taken++;
			serve_request(func, start_address, quantity, write_word, word_last);
		end
	end

	// Watchdog: end the run when neither channel moves a transaction for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int base;
		int sel;
		int a;
		int q;
		logic [7:0] f;
		bit pause_done;
		bit saturate_done;
		pause_done = 1'b0;
		saturate_done = 1'b0;
		foreach (hr_file[i])
			hr_file[i] = '0;

		// Directed part: whole file read while clear, write extremes, range edges
		add_req(FUNC_READ, 16'd0, 16'd32, 16'h0000, 1'b1);
		add_req(FUNC_WRITE1, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
		add_req(FUNC_WRITE1, 16'd31, 16'h0000, 16'h5A5A, 1'b0);
		add_req(FUNC_WRITE1, 16'd32, 16'd1, 16'h1234, 1'b1);
		add_req(FUNC_WRITE1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		// Empty reads in range give the header alone
		add_req(FUNC_READ, 16'd0, 16'd0, 16'h0000, 1'b1);
		add_req(FUNC_READ, 16'd32, 16'd0, 16'h0000, 1'b1);
		add_req(FUNC_READ, 16'd31, 16'd2, 16'h0000, 1'b1);
		// Sum wraps in 16 bits but not in 17
		add_req(FUNC_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		add_write_multi(16'd1, 16'd3, 3, 1'b1);
		add_req(FUNC_READ, 16'd0, 16'd4, 16'h0000, 1'b1);
		// Zero-length multi-write: echo only, nothing written
		add_write_multi(16'd5, 16'd0, 1, 1'b1);
		// Out-of-range multi-write drops its words
		add_write_multi(16'd30, 16'd4, 2, 1'b1);
		// Surplus words past the quantity are ignored
		add_write_multi(16'd10, 16'd2, 4, 1'b1);
		add_req(8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		add_req(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		add_req(8'h80, 16'h0001, 16'h0001, 16'h0001, 1'b0);
		add_req(FUNC_READ, 16'd8, 16'd24, 16'h0000, 1'b1);
		add_drain();

		// Random part: mostly well-formed requests, the rest broken or illegal
		base = stim_items;
		while (stim_items - base < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (!pause_done && stim_items - base >= 140) begin
				add_drain();
				pause_done = 1'b1;
			end else if (!saturate_done && stim_items - base >= 200) begin
				// Run the word counter into saturation
				add_write_multi(16'd0, 16'd2, 70, 1'b1);
				saturate_done = 1'b1;
			end else if (sel < 25) begin
				a = $urandom_range(0, REG_COUNT);
				q = pick_count(REG_COUNT - a);
				add_req(FUNC_READ, 16'(a), 16'(q), 16'($urandom), 1'($urandom_range(0, 1)));
			end else if (sel < 45) begin
				a = $urandom_range(0, REG_COUNT - 1);
				add_req(FUNC_WRITE1, 16'(a), 16'($urandom), 16'($urandom),
					1'($urandom_range(0, 1)));
			end else if (sel < 70) begin
				a = $urandom_range(0, REG_COUNT);
				q = pick_count(REG_COUNT - a);
				add_write_multi(16'(a), 16'(q), q == 0 ? 1 : q, 1'b1);
			end else if (sel < 80) begin
				// Word count off from the quantity, maybe left open for the next request
				a = $urandom_range(0, REG_COUNT + 8);
				q = $urandom_range(0, 12);
				add_write_multi(16'(a), 16'(q), $urandom_range(1, 6), 1'($urandom_range(0, 1)));
			end else if (sel < 88) begin
				a = $urandom_range(0, 65535);
				q = $urandom_range(0, 65535);
				if (a + q <= REG_COUNT)
					q = q + REG_COUNT + 1;
				case ($urandom_range(0, 2))
				0: add_req(FUNC_READ, 16'(a), 16'(q), 16'($urandom), 1'($urandom_range(0, 1)));
				1: begin
					if (a < REG_COUNT)
						a = a + REG_COUNT;
					add_req(FUNC_WRITE1, 16'(a), 16'(q), 16'($urandom),
						1'($urandom_range(0, 1)));
				end
				default: add_write_multi(16'(a), 16'(q), $urandom_range(1, 3), 1'b1);
				endcase
			end else begin
				do
					f = 8'($urandom_range(0, 255));
				while (f == FUNC_READ || f == FUNC_WRITE1 || f == FUNC_WRITEN);
				add_req(f, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for the last transaction to go in, then for every reply to come out
		while (request_q.size() != 0 || in_valid)
			@(posedge clk);
		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
